### hw/rtl/rbei_pkg.sv
// Shared types, constants and helpers for the rigid body Euler integrator.
// Used by every module under hw/rtl; depends on nothing else.
package rbei_pkg;

  localparam int WORD_W     = 32;
  localparam int DT_W       = 17;
  localparam int IM_W       = 25;
  localparam int N_AXES     = 3;
  localparam int AXIS_Y     = 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int SAT_W      = 64;
  localparam int PIPE_DEPTH = 7;

  // Register reset values, raw fixed-point codes
  localparam logic [DT_W-1:0]   RST_TIME_STEP = 17'd1092;
  localparam logic [WORD_W-1:0] RST_GRAVITY   = 32'hFFF6_3A64;
  localparam logic [DT_W-1:0]   RST_DAMPING   = 17'd64881;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIME_STEP = 2'd0,
    CFG_GRAVITY   = 2'd1,
    CFG_DAMPING   = 2'd2
  } cfg_idx_e;

  typedef logic signed [WORD_W-1:0] word_t;

  // Body data that rides along with the arithmetic
  typedef struct packed {
    logic                           is_static;
    logic [N_AXES-1:0][WORD_W-1:0]  pos;
    logic [N_AXES-1:0][WORD_W-1:0]  vel;
  } side_t;

  typedef struct packed {
    logic [WORD_W-1:0] val;
    logic              clip;
  } sat_t;

  // Clip a wide signed value to the 32-bit signed range
  function automatic sat_t sat_word(input logic signed [SAT_W-1:0] v);
    sat_t r;
    r.clip = !((&v[SAT_W-1:WORD_W-1]) || !(|v[SAT_W-1:WORD_W-1]));
    if (r.clip) begin
      r.val = v[SAT_W-1] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
    end else begin
      r.val = v[WORD_W-1:0];
    end
    return r;
  endfunction

endpackage

### hw/rtl/rbei_accel.sv
// Acceleration stages: force times inverse mass, then gravity on y.
// Depends on rbei_pkg. Two register stages.
module rbei_accel #(
  parameter int FRAC_BITS = 16,
  parameter int ACC_W     = 59 - FRAC_BITS
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  rbei_pkg::word_t       force_i [rbei_pkg::N_AXES],
  input  logic [rbei_pkg::IM_W-1:0] im_i,
  input  rbei_pkg::word_t       g_i,
  input  rbei_pkg::side_t       side_i,
  output logic signed [ACC_W-1:0] acc_o [rbei_pkg::N_AXES],
  output rbei_pkg::side_t       side_o
);
  import rbei_pkg::*;

  localparam int PROD_W = WORD_W + IM_W + 1;

  logic signed [PROD_W-1:0] prod_d [N_AXES];
  logic signed [PROD_W-1:0] prod_q [N_AXES];
  logic signed [ACC_W-1:0]  acc_d  [N_AXES];
  logic signed [ACC_W-1:0]  acc_q  [N_AXES];
  side_t                    side_a_q;
  side_t                    side_b_q;

  // Multiply force by inverse mass
  always_comb begin
    for (int i = 0; i < N_AXES; i++) begin
      prod_d[i] = force_i[i] * $signed({1'b0, im_i});
    end
  end

  // Scale down with floor rounding, add gravity on y
  always_comb begin
    logic signed [PROD_W-1:0] sh;
    for (int i = 0; i < N_AXES; i++) begin
      sh = prod_q[i] >>> FRAC_BITS;
      if (i == AXIS_Y) begin
        acc_d[i] = ACC_W'(sh) + ACC_W'(g_i);
      end else begin
        acc_d[i] = ACC_W'(sh);
      end
    end
  end

  // Advance both stages together
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q   <= prod_d;
      acc_q    <= acc_d;
      side_a_q <= side_i;
      side_b_q <= side_a_q;
    end
  end

  assign acc_o  = acc_q;
  assign side_o = side_b_q;

endmodule

### hw/rtl/rbei_vel.sv
// Velocity stages: acceleration times dt as two split products, then add.
// Depends on rbei_pkg. Three register stages.
module rbei_vel #(
  parameter int FRAC_BITS = 16,
  parameter int ACC_W     = 59 - FRAC_BITS
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [ACC_W-1:0] acc_i [rbei_pkg::N_AXES],
  input  logic [rbei_pkg::DT_W-1:0] dt_i,
  input  rbei_pkg::side_t         side_i,
  output rbei_pkg::word_t         vnew_o [rbei_pkg::N_AXES],
  output logic [rbei_pkg::N_AXES-1:0] clip_o,
  output rbei_pkg::side_t         side_o
);
  import rbei_pkg::*;

  localparam int LO_W  = (ACC_W + 1) / 2;
  localparam int HI_W  = ACC_W - LO_W;
  localparam int PL_W  = LO_W + DT_W;
  localparam int PH_W  = HI_W + DT_W + 1;
  localparam int ADT_W = ACC_W + DT_W + 1;

  logic [PL_W-1:0]          pl_d  [N_AXES];
  logic [PL_W-1:0]          pl_q  [N_AXES];
  logic signed [PH_W-1:0]   ph_d  [N_AXES];
  logic signed [PH_W-1:0]   ph_q  [N_AXES];
  logic signed [ADT_W-1:0]  adt_d [N_AXES];
  logic signed [ADT_W-1:0]  adt_q [N_AXES];
  word_t                    vnew_d [N_AXES];
  word_t                    vnew_q [N_AXES];
  logic [N_AXES-1:0]        clip_d;
  logic [N_AXES-1:0]        clip_q;
  side_t                    side_c_q;
  side_t                    side_d_q;
  side_t                    side_e_q;

  // Split the acceleration and multiply each half by dt
  always_comb begin
    for (int i = 0; i < N_AXES; i++) begin
      pl_d[i] = PL_W'(acc_i[i][LO_W-1:0]) * PL_W'(dt_i);
      ph_d[i] = $signed(acc_i[i][ACC_W-1:LO_W]) * $signed({1'b0, dt_i});
    end
  end

  // Recombine the partial products
  always_comb begin
    logic signed [ADT_W-1:0] ph_ext;
    logic signed [ADT_W-1:0] pl_ext;
    for (int i = 0; i < N_AXES; i++) begin
      ph_ext   = ADT_W'(ph_q[i]);
      pl_ext   = ADT_W'(pl_q[i]);
      adt_d[i] = (ph_ext <<< LO_W) + pl_ext;
    end
  end

  // Scale down, add to old velocity, clip
  always_comb begin
    logic signed [ADT_W-1:0] sh;
    logic signed [SAT_W-1:0] sum;
    word_t                   vel;
    sat_t                    s;
    for (int i = 0; i < N_AXES; i++) begin
      sh        = adt_q[i] >>> FRAC_BITS;
      vel       = $signed(side_d_q.vel[i]);
      sum       = SAT_W'(sh) + SAT_W'(vel);
      s         = sat_word(sum);
      vnew_d[i] = $signed(s.val);
      clip_d[i] = s.clip;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pl_q     <= pl_d;
      ph_q     <= ph_d;
      adt_q    <= adt_d;
      vnew_q   <= vnew_d;
      clip_q   <= clip_d;
      side_c_q <= side_i;
      side_d_q <= side_c_q;
      side_e_q <= side_d_q;
    end
  end

  assign vnew_o = vnew_q;
  assign clip_o = clip_q;
  assign side_o = side_e_q;

endmodule

### hw/rtl/rbei_out.sv
// Output stages: position update and velocity damping, with static bypass.
// Depends on rbei_pkg. Two register stages, the second is the output register.
module rbei_out #(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  rbei_pkg::word_t         vnew_i [rbei_pkg::N_AXES],
  input  logic [rbei_pkg::N_AXES-1:0] clip_i,
  input  logic [rbei_pkg::DT_W-1:0] dt_i,
  input  logic [rbei_pkg::DT_W-1:0] damp_i,
  input  rbei_pkg::side_t         side_i,
  output rbei_pkg::word_t         pos_o [rbei_pkg::N_AXES],
  output rbei_pkg::word_t         vel_o [rbei_pkg::N_AXES],
  output logic                    sat_o
);
  import rbei_pkg::*;

  localparam int MP_W = WORD_W + DT_W + 1;

  logic signed [MP_W-1:0] pd_d [N_AXES];
  logic signed [MP_W-1:0] pd_q [N_AXES];
  logic signed [MP_W-1:0] vd_d [N_AXES];
  logic signed [MP_W-1:0] vd_q [N_AXES];
  logic                   clip_f_q;
  side_t                  side_f_q;
  word_t                  pos_d [N_AXES];
  word_t                  pos_q [N_AXES];
  word_t                  vel_d [N_AXES];
  word_t                  vel_q [N_AXES];
  logic                   sat_d;
  logic                   sat_q;

  // Multiply new velocity by dt and by the damping factor
  always_comb begin
    for (int i = 0; i < N_AXES; i++) begin
      pd_d[i] = vnew_i[i] * $signed({1'b0, dt_i});
      vd_d[i] = vnew_i[i] * $signed({1'b0, damp_i});
    end
  end

  // Add displacement, clip both results, bypass static bodies
  always_comb begin
    logic signed [MP_W-1:0]  psh;
    logic signed [MP_W-1:0]  vsh;
    logic signed [SAT_W-1:0] psum;
    word_t                   pos;
    sat_t                    ps;
    sat_t                    vs;
    sat_d = clip_f_q;
    for (int i = 0; i < N_AXES; i++) begin
      psh  = pd_q[i] >>> FRAC_BITS;
      vsh  = vd_q[i] >>> FRAC_BITS;
      pos  = $signed(side_f_q.pos[i]);
      psum = SAT_W'(psh) + SAT_W'(pos);
      ps   = sat_word(psum);
      vs   = sat_word(SAT_W'(vsh));
      pos_d[i] = $signed(ps.val);
      vel_d[i] = $signed(vs.val);
      sat_d    = sat_d | ps.clip | vs.clip;
    end
    if (side_f_q.is_static) begin
      for (int i = 0; i < N_AXES; i++) begin
        pos_d[i] = $signed(side_f_q.pos[i]);
        vel_d[i] = $signed(side_f_q.vel[i]);
      end
      sat_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pd_q     <= pd_d;
      vd_q     <= vd_d;
      clip_f_q <= |clip_i;
      side_f_q <= side_i;
      pos_q    <= pos_d;
      vel_q    <= vel_d;
      sat_q    <= sat_d;
    end
  end

  assign pos_o = pos_q;
  assign vel_o = vel_q;
  assign sat_o = sat_q;

endmodule

### hw/rtl/rigid_body_euler_integrator.sv
// Top level of the rigid body Euler integrator: config registers, valid
// pipeline and stage modules. Depends on rbei_pkg, rbei_accel, rbei_vel, rbei_out.
//
// Usage:
// - Input channel: in_valid_i / in_stall_o carry one body per transaction
//   (position, velocity, force on three axes, inverse mass).
// - Output channel: out_valid_o / out_stall_i carry the updated position,
//   damped velocity and the saturated flag, one result per body.
// - Config port: cfg_we_i writes cfg_data_i into register cfg_idx_i
//   (0 time step, 1 gravity on y, 2 damping); other indexes are ignored.
//   Write only while no body is in flight.
// - From acceptance to out_valid_o a body passes two stages for
//   acceleration, three for the velocity update, two for position and damping.
// - Throughput is one body per cycle while the receiver does not stall; every
//   stage holds a multiply or a wide add.
// - Reset empties the pipeline and loads the default time step, gravity and
//   damping.
// - While the receiver stalls a valid result, the whole pipeline holds and
//   in_stall_o is high; nothing is dropped or repeated.
module rigid_body_euler_integrator #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rbei_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rbei_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [31:0]            pos_x_in_i,
  input  logic signed [31:0]            pos_y_in_i,
  input  logic signed [31:0]            pos_z_in_i,
  input  logic signed [31:0]            vel_x_in_i,
  input  logic signed [31:0]            vel_y_in_i,
  input  logic signed [31:0]            vel_z_in_i,
  input  logic signed [31:0]            force_x_in_i,
  input  logic signed [31:0]            force_y_in_i,
  input  logic signed [31:0]            force_z_in_i,
  input  logic [24:0]                   inverse_mass_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [31:0]            pos_x_out_o,
  output logic signed [31:0]            pos_y_out_o,
  output logic signed [31:0]            pos_z_out_o,
  output logic signed [31:0]            vel_x_out_o,
  output logic signed [31:0]            vel_y_out_o,
  output logic signed [31:0]            vel_z_out_o,
  output logic                          saturated_o
);
  import rbei_pkg::*;

  localparam int ACC_W = WORD_W + IM_W + 2 - FRAC_BITS;

  logic [DT_W-1:0]       time_step_q;
  logic [WORD_W-1:0]     gravity_q;
  logic [DT_W-1:0]       damping_q;
  logic [PIPE_DEPTH-1:0] vld_q;
  logic                  adv;
  word_t                 frc [N_AXES];
  side_t                 side_in;
  logic signed [ACC_W-1:0] acc [N_AXES];
  side_t                 side_acc;
  word_t                 vnew [N_AXES];
  logic [N_AXES-1:0]     vclip;
  side_t                 side_vel;
  word_t                 pos_res [N_AXES];
  word_t                 vel_res [N_AXES];

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q <= RST_TIME_STEP;
      gravity_q   <= RST_GRAVITY;
      damping_q   <= RST_DAMPING;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TIME_STEP: time_step_q <= cfg_data_i[DT_W-1:0];
        CFG_GRAVITY:   gravity_q   <= cfg_data_i[WORD_W-1:0];
        CFG_DAMPING:   damping_q   <= cfg_data_i[DT_W-1:0];
        default:       ;
      endcase
    end
  end

  // Hold every stage while the result register is stalled
  assign adv        = !(vld_q[PIPE_DEPTH-1] && out_stall_i);
  assign in_stall_o = !adv;

  // Advance valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], in_valid_i};
    end
  end

  // Gather the body
  assign frc[0] = force_x_in_i;
  assign frc[1] = force_y_in_i;
  assign frc[2] = force_z_in_i;

  always_comb begin
    side_in.is_static = (inverse_mass_i == '0);
    side_in.pos[0]    = pos_x_in_i;
    side_in.pos[1]    = pos_y_in_i;
    side_in.pos[2]    = pos_z_in_i;
    side_in.vel[0]    = vel_x_in_i;
    side_in.vel[1]    = vel_y_in_i;
    side_in.vel[2]    = vel_z_in_i;
  end

  rbei_accel #(
    .FRAC_BITS (FRAC_BITS),
    .ACC_W     (ACC_W)
  ) u_accel (
    .clk_i   (clk_i),
    .en_i    (adv),
    .force_i (frc),
    .im_i    (inverse_mass_i),
    .g_i     ($signed(gravity_q)),
    .side_i  (side_in),
    .acc_o   (acc),
    .side_o  (side_acc)
  );

  rbei_vel #(
    .FRAC_BITS (FRAC_BITS),
    .ACC_W     (ACC_W)
  ) u_vel (
    .clk_i  (clk_i),
    .en_i   (adv),
    .acc_i  (acc),
    .dt_i   (time_step_q),
    .side_i (side_acc),
    .vnew_o (vnew),
    .clip_o (vclip),
    .side_o (side_vel)
  );

  rbei_out #(
    .FRAC_BITS (FRAC_BITS)
  ) u_out (
    .clk_i  (clk_i),
    .en_i   (adv),
    .vnew_i (vnew),
    .clip_i (vclip),
    .dt_i   (time_step_q),
    .damp_i (damping_q),
    .side_i (side_vel),
    .pos_o  (pos_res),
    .vel_o  (vel_res),
    .sat_o  (saturated_o)
  );

  assign out_valid_o = vld_q[PIPE_DEPTH-1];
  assign pos_x_out_o = pos_res[0];
  assign pos_y_out_o = pos_res[1];
  assign pos_z_out_o = pos_res[2];
  assign vel_x_out_o = vel_res[0];
  assign vel_y_out_o = vel_res[1];
  assign vel_z_out_o = vel_res[2];

  // The pipeline freezes only behind a stalled, valid result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result");

  // A frozen pipeline keeps its valid bits
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("valid bits moved during a stall");

  // An accepted transaction occupies the first stage
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld_q[0])
    else $error("accepted transaction lost at pipeline entry");

endmodule
